[sv/assert_macros.svh]
// Assertion macros for the checker file cnls_checker.sv.
// Needs nothing else; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on the rising edge, suspended while reset is asserted (active low).
`define ASSERT_RST(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/cnls_pkg.sv]
// Types, constants and small functions of the neighbour label share block.
// Standalone package; used by cross_neighbour_label_share and cnls_checker.
`default_nettype none

package cnls_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int MAX_CLASSES = 16;

  localparam int COL_W   = 6;
  localparam int ROW_W   = 6;
  localparam int CLS_W   = 4;
  localparam int SHARE_W = 16;
  localparam int LAB_W   = 5;

  // One label store of three row slots, addressed as {slot, column}.
  localparam int ROWS_KEPT = 3;
  localparam int MEM_DEPTH = ROWS_KEPT * MAX_WIDTH;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CLASSES = 2'd2;

  localparam logic [SHARE_W-1:0] SHARE_ONE = 16'd32768;

  typedef struct packed {
    logic signed [LAB_W-1:0] label;
    logic                    frame_start;
  } cnls_in_t;

  typedef struct packed {
    logic [COL_W-1:0]   cell_col;
    logic [ROW_W-1:0]   cell_row;
    logic [CLS_W-1:0]   class_id;
    logic [SHARE_W-1:0] share;
    logic               last_of_cell;
  } cnls_out_t;

  // Negative labels and labels at or above the class count do not count.
  function automatic logic label_ok(input logic [LAB_W-1:0] lab,
                                    input logic [4:0] ncls);
    return !lab[LAB_W-1] && ({1'b0, lab[CLS_W-1:0]} < ncls);
  endfunction

  // floor(cnt * 32768 / sum) for sum 1..5, cnt 0..sum.
  function automatic logic [SHARE_W-1:0] share_q15(input logic [2:0] cnt,
                                                   input logic [2:0] sum);
    logic [SHARE_W-1:0] res;
    res = '0;
    case ({sum, cnt})
      {3'd1, 3'd1}: res = 16'd32768;
      {3'd2, 3'd1}: res = 16'd16384;
      {3'd2, 3'd2}: res = 16'd32768;
      {3'd3, 3'd1}: res = 16'd10922;
      {3'd3, 3'd2}: res = 16'd21845;
      {3'd3, 3'd3}: res = 16'd32768;
      {3'd4, 3'd1}: res = 16'd8192;
      {3'd4, 3'd2}: res = 16'd16384;
      {3'd4, 3'd3}: res = 16'd24576;
      {3'd4, 3'd4}: res = 16'd32768;
      {3'd5, 3'd1}: res = 16'd6553;
      {3'd5, 3'd2}: res = 16'd13107;
      {3'd5, 3'd3}: res = 16'd19660;
      {3'd5, 3'd4}: res = 16'd26214;
      {3'd5, 3'd5}: res = 16'd32768;
      default:      res = '0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/cross_neighbour_label_share.sv]
// Top level: label map line stores and per-class neighbour share output.
// Depends on cnls_pkg.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+----------------------------------
//  in       | in  | in_valid_i/in_ready_o  | in_data_i  (label, frame_start)
//  out      | out | out_valid_o/out_ready_i| out_data_o (col,row,class,share,last)
//  config   | in  | APB, pready tied high  | map_width, map_height, class_count
//
// Border cells, cells past the map and class_count 0 leave the block idle. An
// interior cell reads the single-port label store four times (registered read
// data), then emits one result per class if its centre is valid, else idles.
// Output stalls hold the emit loop; in_ready_o is low until the last result
// is loaded into the output register. Reset clears counters and config to
// 64/64/16; the label store is not cleared.
`default_nettype none

module cross_neighbour_label_share (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  cnls_pkg::cnls_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output cnls_pkg::cnls_out_t            out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cnls_pkg::APB_AW-1:0]    paddr,
  input  logic [cnls_pkg::APB_DW-1:0]    pwdata,
  output logic [cnls_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);
  import cnls_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  // configuration
  logic [6:0] width_q, height_q;
  logic [4:0] ncls_q;
  logic [6:0] w_eff, h_eff;
  logic [4:0] ncls_eff;
  logic       apb_wr;

  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 7'(MAX_WIDTH);
      height_q <= 7'(MAX_HEIGHT);
      ncls_q   <= 5'(MAX_CLASSES);
    end else if (apb_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:   width_q  <= pwdata[6:0];
        REG_HEIGHT:  height_q <= pwdata[6:0];
        REG_CLASSES: ncls_q   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:   prdata = APB_DW'(width_q);
      REG_HEIGHT:  prdata = APB_DW'(height_q);
      REG_CLASSES: prdata = APB_DW'(ncls_q);
      default:     prdata = '0;
    endcase
  end

  assign w_eff    = (width_q == '0) ? 7'd1 :
                    (width_q > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width_q;
  assign h_eff    = (height_q == '0) ? 7'd1 :
                    (height_q > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : height_q;
  assign ncls_eff = (ncls_q > 5'(MAX_CLASSES)) ? 5'(MAX_CLASSES) : ncls_q;

  // control state
  state_e           state_q, state_d;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [1:0]       slot_q;          // row_q mod 3
  logic [2:0]       step_q;
  logic [CLS_W-1:0] cls_q;
  logic             out_valid_q;

  // per-cell payload
  logic [COL_W-1:0] ccol_q;
  logic [ROW_W-1:0] crow_q;
  logic [1:0]       mid_slot_q, up_slot_q;
  logic [LAB_W-1:0] nbr_q [5];       // centre, left, right, up, down
  logic [2:0]       nbr_idx;
  cnls_out_t        out_q;

  // label store
  logic [LAB_W-1:0]  mem_q [MEM_DEPTH];
  logic [LAB_W-1:0]  mem_rdata_q;
  logic [MEM_AW-1:0] mem_raddr;
  logic              mem_re;

  // input side
  logic             in_xfer;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [1:0]       cur_slot;
  logic [LAB_W-1:0] in_lab;
  logic             col_last, col_inner, row_inner, need_out;
  logic [6:0]       col_next;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_lab     = in_data_i.label;
  assign cur_col    = in_data_i.frame_start ? '0 : col_q;
  assign cur_row    = in_data_i.frame_start ? '0 : row_q;
  assign cur_slot   = in_data_i.frame_start ? 2'd0 : slot_q;
  assign col_next   = {1'b0, cur_col} + 7'd1;
  assign col_last   = (col_next >= w_eff);
  assign col_inner  = (cur_col != '0) && (col_next < w_eff);
  assign row_inner  = (cur_row >= ROW_W'(2)) && ({1'b0, cur_row} < h_eff);
  assign need_out   = col_inner && row_inner && (ncls_eff != '0);

  // Reads touch the two older row slots; the write goes to the current one,
  // and no write happens while reads are in flight, so no forwarding.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mem_q[{cur_slot, cur_col}] <= in_lab;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  assign mem_re = (state_q == ST_READ) && (step_q < 3'd4);

  always_comb begin
    case (step_q)
      3'd0:    mem_raddr = {mid_slot_q, ccol_q};
      3'd1:    mem_raddr = {mid_slot_q, ccol_q - COL_W'(1)};
      3'd2:    mem_raddr = {mid_slot_q, ccol_q + COL_W'(1)};
      3'd3:    mem_raddr = {up_slot_q, ccol_q};
      default: mem_raddr = {mid_slot_q, ccol_q};
    endcase
  end

  // share for the class being emitted
  logic [2:0]         cnt, sum;
  logic               last_cls, emit_load, centre_ok;
  logic [SHARE_W-1:0] share;

  always_comb begin
    cnt = 3'((nbr_q[0][CLS_W-1:0] == cls_q) ? 1 : 0);
    sum = 3'd1;
    for (int k = 1; k < 5; k++) begin
      if (label_ok(nbr_q[k], ncls_eff)) begin
        sum = sum + 3'd1;
        if (nbr_q[k][CLS_W-1:0] == cls_q) begin
          cnt = cnt + 3'd1;
        end
      end
    end
  end

  assign share     = share_q15(cnt, sum);
  assign last_cls  = ({1'b0, cls_q} + 5'd1) == ncls_eff;
  assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign centre_ok = label_ok(nbr_q[0], ncls_eff);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_xfer && need_out) state_d = ST_READ;
      ST_READ: begin
        if (step_q == 3'd4) begin
          state_d = centre_ok ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: if (emit_load && last_cls) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      slot_q      <= 2'd0;
      step_q      <= '0;
      cls_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        if (col_last) begin
          col_q <= '0;
          if (cur_row == ROW_W'(MAX_HEIGHT - 1)) begin
            row_q  <= '0;
            slot_q <= 2'd0;
          end else begin
            row_q  <= cur_row + ROW_W'(1);
            slot_q <= (cur_slot == 2'd2) ? 2'd0 : cur_slot + 2'd1;
          end
        end else begin
          col_q  <= col_next[COL_W-1:0];
          row_q  <= cur_row;
          slot_q <= cur_slot;
        end
      end
      if (state_q == ST_READ) begin
        step_q <= step_q + 3'd1;
      end else begin
        step_q <= '0;
      end
      if (state_q == ST_READ) begin
        cls_q <= '0;
      end else if (emit_load) begin
        cls_q <= cls_q + CLS_W'(1);
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // read data is registered, so it trails the read address
  assign nbr_idx = step_q - 3'd1;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ccol_q     <= cur_col;
      crow_q     <= cur_row - ROW_W'(1);
      mid_slot_q <= (cur_slot == 2'd0) ? 2'd2 : cur_slot - 2'd1;
      up_slot_q  <= (cur_slot == 2'd2) ? 2'd0 : cur_slot + 2'd1;
      nbr_q[4]   <= in_lab;
    end
    if (state_q == ST_READ && step_q != '0) begin
      nbr_q[nbr_idx] <= mem_rdata_q;
    end
    if (emit_load) begin
      out_q.cell_col     <= ccol_q;
      out_q.cell_row     <= crow_q;
      out_q.class_id     <= cls_q;
      out_q.share        <= share;
      out_q.last_of_cell <= last_cls;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[sv/cnls_checker.sv]
// Port-level checks for cross_neighbour_label_share, bound to the top level.
// Depends on cnls_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module cnls_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_ready_o,
  input  logic                           out_valid_o,
  input  logic                           out_ready_i,
  input  cnls_pkg::cnls_out_t            out_data_o
);
  import cnls_pkg::*;

  logic out_stall, share_ok, top_cls, mid_cell;

  assign out_stall = out_valid_o && !out_ready_i;
  assign share_ok  = out_data_o.share <= SHARE_ONE;
  assign top_cls   = out_data_o.class_id == CLS_W'(MAX_CLASSES - 1);
  assign mid_cell  = !out_data_o.last_of_cell;

  property p_out_hold;
    out_stall |=> out_valid_o && $stable(out_data_o);
  endproperty

  // a stalled result keeps its value
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, p_out_hold, "stalled result changed")

  // share is a fraction of one
  `ASSERT_RST(a_share_range, clk_i, rst_ni, out_valid_o |-> share_ok, "share above one")

  // the highest class is always the last of its cell
  `ASSERT_RST(a_last_class, clk_i, rst_ni, out_valid_o && top_cls |-> !mid_cell, "top class not last")

  // while a cell still has results to emit, no new cell is taken
  `ASSERT_RST(a_cell_order, clk_i, rst_ni, out_valid_o && mid_cell |-> !in_ready_o, "input mid cell")

endmodule

bind cross_neighbour_label_share cnls_checker u_cnls_checker (.*);

`default_nettype wire
